[hdl/lpc_pkg.sv]
package lpc_pkg;

  localparam int NLANE     = 6;
  localparam int DIV_STEPS = 64;

  // Lane order of the six distinct entries: xx, xy, xz, yy, yz, zz.
  localparam int LANE_ROW [NLANE] = '{0, 0, 0, 1, 1, 2};
  localparam int LANE_COL [NLANE] = '{0, 1, 2, 1, 2, 2};
  // Lane holding the square of each coordinate.
  localparam int DIAG_LANE [3] = '{0, 3, 5};

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  localparam logic [31:0] RANGE_SIGMA_RST  = 32'd655;
  localparam logic [31:0] ANGLE_SIN_SQ_RST = 32'd429482;
  localparam logic [63:0] RANGE_SQ_RST     = 64'd429025;

  typedef enum logic {
    CFG_RANGE_SIGMA  = 1'b0,
    CFG_ANGLE_SIN_SQ = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NLANE-1:0]        lane;
    logic [NLANE-1:0][63:0]       amag;
    logic [NLANE-1:0]             neg;
    logic [63:0]                  d;
    logic                         zero;
  } div_word_t;

  typedef struct packed {
    logic [NLANE-1:0][63:0] cov;
  } res_t;

endpackage

[hdl/lpc_front.sv]
module lpc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       px_i,
  input  logic [31:0]       py_i,
  input  logic [31:0]       pz_i,
  input  logic [63:0]       range_sq_i,
  input  logic [31:0]       angle_sin_sq_i,
  output logic              valid_o,
  output lpc_pkg::div_word_t word_o
);
  import lpc_pkg::*;

  // Stage 1: magnitudes, signs and the two special cases.
  logic              v1_q;
  logic [2:0][31:0]  mag1_q;
  logic [2:0]        sgn1_q;
  logic              zero1_q, degen1_q;
  logic [2:0][31:0]  pin;
  logic [32:0]       sum_xy;

  assign pin[0] = px_i;
  assign pin[1] = py_i;
  assign pin[2] = pz_i;
  assign sum_xy = {px_i[31], px_i} + {py_i[31], py_i};

  // Stage 2: coordinate products.
  logic                   v2_q;
  logic [NLANE-1:0][63:0] prod2_q;
  logic [NLANE-1:0]       neg2_q;
  logic                   zero2_q, degen2_q;

  // Stage 3: squared range and the bearing multiplicands.
  logic                   v3_q;
  logic [63:0]            r2_3_q;
  logic [NLANE-1:0][63:0] prod3_q, bmul3_q;
  logic [NLANE-1:0]       neg3_q;
  logic                   zero3_q, degen3_q;

  // Stage 4: 32x32 partial products.
  logic                   v4_q;
  logic [63:0]            r2_4_q;
  logic [NLANE-1:0][63:0] rll_q, rlh_q, rhl_q, rhh_q, al_q, ah_q;
  logic [NLANE-1:0]       neg4_q;
  logic                   zero4_q, degen4_q;

  // Stage 5: full numerator and truncated bearing term.
  logic      v5_q;
  div_word_t w5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        sgn1_q[c] <= pin[c][31];
        mag1_q[c] <= pin[c][31] ? (~pin[c] + 32'd1) : pin[c];
      end
      zero1_q  <= (px_i == 32'd0) && (py_i == 32'd0) && (pz_i == 32'd0);
      degen1_q <= (pz_i == 32'd0) && (sum_xy == 33'd0);

      for (int k = 0; k < NLANE; k++) begin
        prod2_q[k] <= mag1_q[LANE_ROW[k]] * mag1_q[LANE_COL[k]];
        neg2_q[k]  <= sgn1_q[LANE_ROW[k]] ^ sgn1_q[LANE_COL[k]];
      end
      zero2_q  <= zero1_q;
      degen2_q <= degen1_q;

      r2_3_q <= prod2_q[DIAG_LANE[0]] + prod2_q[DIAG_LANE[1]] + prod2_q[DIAG_LANE[2]];
      for (int k = 0; k < NLANE; k++) begin
        prod3_q[k] <= prod2_q[k];
        if (LANE_ROW[k] == LANE_COL[k]) begin
          // r2 minus the own square is the sum of the other two squares.
          bmul3_q[k] <= prod2_q[DIAG_LANE[(LANE_ROW[k] + 1) % 3]]
                      + prod2_q[DIAG_LANE[(LANE_ROW[k] + 2) % 3]];
        end else begin
          bmul3_q[k] <= prod2_q[k];
        end
      end
      neg3_q   <= neg2_q;
      zero3_q  <= zero2_q;
      degen3_q <= degen2_q;

      for (int k = 0; k < NLANE; k++) begin
        rll_q[k] <= range_sq_i[31:0]  * prod3_q[k][31:0];
        rlh_q[k] <= range_sq_i[31:0]  * prod3_q[k][63:32];
        rhl_q[k] <= range_sq_i[63:32] * prod3_q[k][31:0];
        rhh_q[k] <= range_sq_i[63:32] * prod3_q[k][63:32];
        al_q[k]  <= angle_sin_sq_i * bmul3_q[k][31:0];
        ah_q[k]  <= angle_sin_sq_i * bmul3_q[k][63:32];
      end
      r2_4_q   <= r2_3_q;
      neg4_q   <= neg3_q;
      zero4_q  <= zero3_q;
      degen4_q <= degen3_q;

      for (int k = 0; k < NLANE; k++) begin
        {w5_q.lane[k].rem, w5_q.lane[k].num} <= {rhh_q[k], 64'd0}
                                             + {32'd0, rlh_q[k], 32'd0}
                                             + {32'd0, rhl_q[k], 32'd0}
                                             + {64'd0, rll_q[k]};
        w5_q.lane[k].quo <= 64'd0;
        // A degenerate bearing basis drops the angle term entirely.
        w5_q.amag[k] <= degen4_q ? 64'd0 : (ah_q[k] + {32'd0, al_q[k][63:32]});
      end
      w5_q.neg  <= neg4_q;
      w5_q.d    <= r2_4_q;
      w5_q.zero <= zero4_q;
    end
  end

  assign valid_o = v5_q;
  assign word_o  = w5_q;

endmodule

[hdl/lpc_div.sv]
module lpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  lpc_pkg::div_word_t word_i,
  output logic               valid_o,
  output lpc_pkg::div_word_t word_o
);
  import lpc_pkg::*;

  // One restoring quotient bit per stage, all six lanes side by side.
  function automatic div_word_t div_step(div_word_t w);
    div_word_t   r;
    logic [64:0] rem2;
    logic        ge;
    r = w;
    for (int k = 0; k < NLANE; k++) begin
      rem2 = {w.lane[k].rem, w.lane[k].num[63]};
      ge   = (rem2 >= {1'b0, w.d});
      r.lane[k].rem = ge ? 64'(rem2 - {1'b0, w.d}) : rem2[63:0];
      r.lane[k].num = {w.lane[k].num[62:0], 1'b0};
      r.lane[k].quo = {w.lane[k].quo[62:0], ge};
    end
    return r;
  endfunction

  div_word_t stg_w [DIV_STEPS+1];
  logic      vld_w [DIV_STEPS+1];

  assign stg_w[0] = word_i;
  assign vld_w[0] = valid_i;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    div_word_t w_q;
    logic      v_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= vld_w[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q <= div_step(stg_w[g]);
      end
    end

    assign stg_w[g+1] = w_q;
    assign vld_w[g+1] = v_q;
  end

  assign valid_o = vld_w[DIV_STEPS];
  assign word_o  = stg_w[DIV_STEPS];

endmodule

[hdl/lpc_out.sv]
module lpc_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lpc_pkg::div_word_t word_i,
  output logic               en_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lpc_pkg::res_t      res_o
);
  import lpc_pkg::*;

  res_t res_d;
  res_t out_q, skid_q;
  logic out_v_q, skid_v_q;
  logic pop;

  always_comb begin
    logic [63:0] rmag, amag, mag;
    logic [64:0] s;
    logic        ge, nneg;
    for (int k = 0; k < NLANE; k++) begin
      rmag = word_i.lane[k].quo;
      amag = word_i.amag[k];
      s    = {1'b0, rmag} + {1'b0, amag};
      ge   = (rmag >= amag);
      mag  = ge ? (rmag - amag) : (amag - rmag);
      nneg = ge ? (word_i.neg[k] && (rmag != amag)) : !word_i.neg[k];
      if (word_i.zero) begin
        res_d.cov[k] = 64'd0;
      end else if (LANE_ROW[k] == LANE_COL[k]) begin
        res_d.cov[k] = (s[64] || s[63]) ? SAT_MAX : s[63:0];
      end else if (nneg) begin
        res_d.cov[k] = mag[63] ? SAT_MIN : (~mag + 64'd1);
      end else begin
        res_d.cov[k] = mag[63] ? SAT_MAX : mag;
      end
    end
  end

  assign pop  = out_v_q && out_ready_i;
  assign en_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || pop) begin
      out_v_q <= valid_i;
    end else if (valid_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || pop) begin
      out_q <= res_d;
    end else begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid holds a result ahead of the output");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !pop |=> skid_v_q && $stable(skid_q))
    else $error("skid result changed while the output was stalled");

  a_diag_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !out_q.cov[0][63] && !out_q.cov[3][63] && !out_q.cov[5][63])
    else $error("diagonal covariance entry is negative");
`endif

endmodule

[hdl/lidar_point_covariance.sv]
// Range-bearing covariance of one lidar point per request.
// Input channel: in_valid_i / in_ready_o carry px_i, py_i, pz_i (signed Q16.16).
// Output channel: out_valid_o / out_ready_i carry the six distinct entries
// cov_xx_o .. cov_zz_o of the symmetric 3x3 matrix (signed Q32.32, saturated).
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 range_sigma, 1 angle_sin_sq); write only while no request is in flight.
// A request passes 70 register stages: five arithmetic stages, a 64-stage
// divider producing one quotient bit per stage, and the output register. The
// first is loaded at the accepting edge and out_valid_o rises when the result
// reaches the output register. Throughput is one request per cycle while the
// output is not stalled, set by the fully pipelined divider and multipliers.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the output register holds its result and a one-entry
// skid buffer catches the next one; in_ready_o then drops and the whole
// pipeline freezes until the output is taken.
module lidar_point_covariance (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] px_i,
  input  logic [31:0] py_i,
  input  logic [31:0] pz_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cov_xx_o,
  output logic [63:0] cov_xy_o,
  output logic [63:0] cov_xz_o,
  output logic [63:0] cov_yy_o,
  output logic [63:0] cov_yz_o,
  output logic [63:0] cov_zz_o
);
  import lpc_pkg::*;

  logic [31:0] range_sigma_q, angle_sin_sq_q;
  logic [63:0] range_sq_q;
  logic        en;
  logic        front_v, div_v;
  div_word_t   front_w, div_w;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_sigma_q  <= RANGE_SIGMA_RST;
      angle_sin_sq_q <= ANGLE_SIN_SQ_RST;
      range_sq_q     <= RANGE_SQ_RST;
    end else begin
      range_sq_q <= range_sigma_q * range_sigma_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_RANGE_SIGMA:  range_sigma_q  <= cfg_wdata_i;
          CFG_ANGLE_SIN_SQ: angle_sin_sq_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign in_ready_o = en;

  lpc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_i),
    .px_i           (px_i),
    .py_i           (py_i),
    .pz_i           (pz_i),
    .range_sq_i     (range_sq_q),
    .angle_sin_sq_i (angle_sin_sq_q),
    .valid_o        (front_v),
    .word_o         (front_w)
  );

  lpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .word_i  (front_w),
    .valid_o (div_v),
    .word_o  (div_w)
  );

  lpc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (div_v),
    .word_i      (div_w),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign cov_xx_o = res.cov[0];
  assign cov_xy_o = res.cov[1];
  assign cov_xz_o = res.cov[2];
  assign cov_yy_o = res.cov[3];
  assign cov_yz_o = res.cov[4];
  assign cov_zz_o = res.cov[5];

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lpc_pkg::*;

  typedef struct packed {
    logic [63:0] xx, xy, xz, yy, yz, zz;
  } cov_t;

  localparam int LATENCY = 70;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] px_i, py_i, pz_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] cov_xx_o, cov_xy_o, cov_xz_o, cov_yy_o, cov_yz_o, cov_zz_o;

  lidar_point_covariance u_top (.*);

  // Local copy of the two registers for the predictor.
  logic [31:0] range_sigma_q;
  logic [31:0] angle_sin_sq_q;

  cov_t expected_cov_q[$];
  int   error_count;
  int   points_sent;
  int   covs_checked;
  int   cfg_writes;
  longint unsigned cycle_count;
  bit   hold_off;       // long receiver stall requested
  int   hold_cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] mag_of(logic signed [31:0] v);
    logic [63:0] w;
    w = {{32{v[31]}}, v};
    return v[31] ? -w : w;
  endfunction

  function automatic logic [63:0] sat_entry(bit neg, logic [63:0] mag, bit ovf);
    if (neg) begin
      if (ovf || mag >= SAT_MIN) return SAT_MIN;
      return -mag;
    end
    if (ovf || mag > SAT_MAX) return SAT_MAX;
    return mag;
  endfunction

  function automatic cov_t predict_cov(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [63:0]  mg[3];
    logic [63:0]  sq[3];
    logic [63:0]  r2, rs2, prod, rmag, amag, v, s;
    logic [127:0] wide, quo;
    logic [63:0]  res[6];
    logic [32:0]  sum_xy;
    bit           neg[3];
    bit           use_bearing, prod_neg, big;
    int           rw[6];
    int           cl[6];
    cov_t         c;
    rw = '{0, 0, 0, 1, 1, 2};
    cl = '{0, 1, 2, 1, 2, 2};
    mg[0] = mag_of(x); mg[1] = mag_of(y); mg[2] = mag_of(z);
    neg[0] = x[31]; neg[1] = y[31]; neg[2] = z[31];
    for (int k = 0; k < 3; k++) sq[k] = mg[k] * mg[k];
    r2 = sq[0] + sq[1] + sq[2];
    if (r2 == 0) return '0;
    // x = -y is checked on the full range, so that -2^31 is not its own negation.
    sum_xy = {x[31], x} + {y[31], y};
    use_bearing = !(z == 0 && sum_xy == 33'd0);
    rs2 = {32'd0, range_sigma_q} * {32'd0, range_sigma_q};
    for (int k = 0; k < 6; k++) begin
      prod = mg[rw[k]] * mg[cl[k]];
      prod_neg = neg[rw[k]] != neg[cl[k]];
      wide = {64'd0, rs2} * {64'd0, prod};
      quo = wide / {64'd0, r2};
      big = quo[127:64] != 0;
      rmag = quo[63:0];
      amag = 0;
      if (use_bearing) begin
        v = (rw[k] == cl[k]) ? r2 - sq[rw[k]] : prod;
        wide = {96'd0, angle_sin_sq_q} * {64'd0, v};
        amag = wide[95:32];
      end
      if (rw[k] == cl[k]) begin
        s = rmag + amag;
        res[k] = sat_entry(0, s, big || s < rmag);
      end else if (big) begin
        res[k] = sat_entry(prod_neg, 0, 1);
      end else if (rmag >= amag) begin
        res[k] = sat_entry(prod_neg && rmag != amag, rmag - amag, 0);
      end else begin
        res[k] = sat_entry(!prod_neg, amag - rmag, 0);
      end
    end
    c.xx = res[0]; c.xy = res[1]; c.xz = res[2];
    c.yy = res[3]; c.yz = res[4]; c.zz = res[5];
    return c;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sends one point; the prediction is queued at the accepting edge.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps = 1);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    px_i <= x;
    py_i <= y;
    pz_i <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_cov_q.push_back(predict_cov(x, y, z));
    points_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_cov_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_RANGE_SIGMA) range_sigma_q = value;
    else angle_sin_sq_q = value;
    cfg_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 32'h00C8_0000) * ($urandom_range(0, 1) ? 1 : -1);
    if (r < 7) return $urandom();
    if (r == 7) return 32'h0;
    if (r == 8) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom_range(0, 15) - 8;
  endfunction

  task automatic test_directed_points();
    logic [31:0] c[8];
    c = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h0001_0000, 32'hFFFF_0000, 32'h0A00_0000};
    send_point(0, 0, 0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 0);       // degenerate basis
    send_point(32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0001, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    for (int i = 0; i < 8; i++) send_point(c[i], c[(i + 3) % 8], c[(i + 5) % 8]);
    send_point(32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
    drain();
  endtask

  task automatic test_config_extremes();
    logic [31:0] rs[4];
    logic [31:0] as[4];
    rs = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd655};
    as = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'd429482};
    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_RANGE_SIGMA, rs[s]);
      write_reg(CFG_ANGLE_SIN_SQ, as[s]);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      send_point(32'h0005_0000, 32'hFFFB_0000, 0);
      send_point(32'h0000_0001, 0, 0);
      repeat (40) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  task automatic test_random_points();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_RANGE_SIGMA, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0004_0000));
      write_reg(CFG_ANGLE_SIN_SQ, $urandom());
      repeat (130) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  task automatic test_backpressure();
    // Receiver stalls for a long stretch while points keep coming.
    hold_cycles = 200;
    hold_off = 1'b1;
    repeat (100) send_point(rand_coord(), rand_coord(), rand_coord(), 0);
    // Sender pauses until every expected result is back.
    in_valid_i <= 1'b0;
    while (expected_cov_q.size() != 0) @(posedge clk_i);
    repeat (30) send_point(rand_coord(), rand_coord(), rand_coord(), 0);
    drain();
  endtask

  // Receiver side: random ready, with a long hold-off when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off) begin
      out_ready_i <= 1'b0;
      if (hold_cycles == 0) hold_off <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else begin
      r = $urandom_range(0, 99);
      out_ready_i <= (r < 65) ? 1'b1 : (r < 97) ? $urandom_range(0, 1) : 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cov_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cov_q.size() == 0) begin
        $error("covariance result with no point outstanding");
        error_count++;
      end else begin
        exp_c = expected_cov_q.pop_front();
        covs_checked++;
        if (cov_xx_o !== exp_c.xx) begin
          $error("cov_xx exp %h got %h", exp_c.xx, cov_xx_o); error_count++;
        end
        if (cov_xy_o !== exp_c.xy) begin
          $error("cov_xy exp %h got %h", exp_c.xy, cov_xy_o); error_count++;
        end
        if (cov_xz_o !== exp_c.xz) begin
          $error("cov_xz exp %h got %h", exp_c.xz, cov_xz_o); error_count++;
        end
        if (cov_yy_o !== exp_c.yy) begin
          $error("cov_yy exp %h got %h", exp_c.yy, cov_yy_o); error_count++;
        end
        if (cov_yz_o !== exp_c.yz) begin
          $error("cov_yz exp %h got %h", exp_c.yz, cov_yz_o); error_count++;
        end
        if (cov_zz_o !== exp_c.zz) begin
          $error("cov_zz exp %h got %h", exp_c.zz, cov_zz_o); error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    cycle_count = 0;
    error_count = 0;
    points_sent = 0;
    covs_checked = 0;
    cfg_writes = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_RANGE_SIGMA;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    px_i = '0;
    py_i = '0;
    pz_i = '0;
    range_sigma_q = RANGE_SIGMA_RST;
    angle_sin_sq_q = ANGLE_SIN_SQ_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_points();
    test_config_extremes();
    test_random_points();
    test_backpressure();

    if (expected_cov_q.size() != 0) begin
      $error("%0d covariance results never arrived", expected_cov_q.size());
      error_count++;
    end
    $display("Sent %0d points, checked %0d covariances, %0d register writes,",
             points_sent, covs_checked, cfg_writes);
    $display("including zero, degenerate-basis and saturating points under stalls.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hdl/lpc_pkg.sv
hdl/lpc_front.sv
hdl/lpc_div.sv
hdl/lpc_out.sv
hdl/lidar_point_covariance.sv
tb/sv/tb.sv
